### rtl/scancode_to_ascii_with_fifo_defines.svh
// assertion macros used by the checker file
`ifndef SCANCODE_TO_ASCII_WITH_FIFO_DEFINES_SVH
`define SCANCODE_TO_ASCII_WITH_FIFO_DEFINES_SVH

// concurrent check, masked while reset is high
`define SC2A_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sc2a check failed");

// concurrent check that also covers the reset cycles
`define SC2A_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sc2a check failed");

`endif

### rtl/sc2a_pkg.sv
`default_nettype none

package sc2a_pkg;

   // default character queue depth
   localparam int FIFO_DEPTH_DEFAULT = 64;

   // command codes
   localparam logic [1:0] CMD_SCAN  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // set-1 key codes with a special meaning
   localparam logic [6:0] KEY_ENTER     = 7'h1C;
   localparam logic [6:0] KEY_BACKSPACE = 7'h0E;
   localparam logic [6:0] KEY_TAB       = 7'h0F;
   localparam logic [6:0] KEY_LSHIFT    = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT    = 7'h36;
   localparam logic [6:0] KEY_CTRL      = 7'h1D;
   localparam logic [6:0] KEY_ALT       = 7'h38;
   localparam logic [6:0] KEY_CAPS      = 7'h3A;

   // bit of the scancode byte that marks a release
   localparam int RELEASE_BIT = 7;

   // control characters for the special keys
   localparam logic [6:0] ASCII_NEWLINE   = 7'h0A;
   localparam logic [6:0] ASCII_BACKSPACE = 7'h08;
   localparam logic [6:0] ASCII_TAB       = 7'h09;
   localparam logic [6:0] ASCII_NONE      = 7'h00;

   // queue commands, already qualified against full and empty
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctrl_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // key to character lookup, lower and upper layouts
   function automatic logic [6:0] key_to_char(input logic upper, input logic [6:0] key);
      logic [6:0] lo;
      logic [6:0] up;
      unique case (key)
         7'h02: begin lo = 7'h31; up = 7'h21; end
         7'h03: begin lo = 7'h32; up = 7'h40; end
         7'h04: begin lo = 7'h33; up = 7'h23; end
         7'h05: begin lo = 7'h34; up = 7'h24; end
         7'h06: begin lo = 7'h35; up = 7'h25; end
         7'h07: begin lo = 7'h36; up = 7'h5E; end
         7'h08: begin lo = 7'h37; up = 7'h26; end
         7'h09: begin lo = 7'h38; up = 7'h2A; end
         7'h0A: begin lo = 7'h39; up = 7'h28; end
         7'h0B: begin lo = 7'h30; up = 7'h29; end
         7'h0C: begin lo = 7'h2D; up = 7'h5F; end
         7'h0D: begin lo = 7'h3D; up = 7'h2B; end
         7'h10: begin lo = 7'h71; up = 7'h51; end
         7'h11: begin lo = 7'h77; up = 7'h57; end
         7'h12: begin lo = 7'h65; up = 7'h45; end
         7'h13: begin lo = 7'h72; up = 7'h52; end
         7'h14: begin lo = 7'h74; up = 7'h54; end
         7'h15: begin lo = 7'h79; up = 7'h59; end
         7'h16: begin lo = 7'h75; up = 7'h55; end
         7'h17: begin lo = 7'h69; up = 7'h49; end
         7'h18: begin lo = 7'h6F; up = 7'h4F; end
         7'h19: begin lo = 7'h70; up = 7'h50; end
         7'h1A: begin lo = 7'h5B; up = 7'h7B; end
         7'h1B: begin lo = 7'h5D; up = 7'h7D; end
         7'h1E: begin lo = 7'h61; up = 7'h41; end
         7'h1F: begin lo = 7'h73; up = 7'h53; end
         7'h20: begin lo = 7'h64; up = 7'h44; end
         7'h21: begin lo = 7'h66; up = 7'h46; end
         7'h22: begin lo = 7'h67; up = 7'h47; end
         7'h23: begin lo = 7'h68; up = 7'h48; end
         7'h24: begin lo = 7'h6A; up = 7'h4A; end
         7'h25: begin lo = 7'h6B; up = 7'h4B; end
         7'h26: begin lo = 7'h6C; up = 7'h4C; end
         7'h27: begin lo = 7'h3B; up = 7'h3A; end
         7'h28: begin lo = 7'h27; up = 7'h22; end
         7'h29: begin lo = 7'h60; up = 7'h7E; end
         7'h2B: begin lo = 7'h5C; up = 7'h7C; end
         7'h2C: begin lo = 7'h7A; up = 7'h5A; end
         7'h2D: begin lo = 7'h78; up = 7'h58; end
         7'h2E: begin lo = 7'h63; up = 7'h43; end
         7'h2F: begin lo = 7'h76; up = 7'h56; end
         7'h30: begin lo = 7'h62; up = 7'h42; end
         7'h31: begin lo = 7'h6E; up = 7'h4E; end
         7'h32: begin lo = 7'h6D; up = 7'h4D; end
         7'h33: begin lo = 7'h2C; up = 7'h3C; end
         7'h34: begin lo = 7'h2E; up = 7'h3E; end
         7'h35: begin lo = 7'h2F; up = 7'h3F; end
         7'h37: begin lo = 7'h2A; up = 7'h2A; end
         7'h39: begin lo = 7'h20; up = 7'h20; end
         default: begin lo = ASCII_NONE; up = ASCII_NONE; end
      endcase
      return upper ? up : lo;
   endfunction

endpackage

`default_nettype wire

### rtl/sc2a_if.sv
`default_nettype none

// request channel: command and scancode byte
interface sc2a_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] scan_byte;

   modport source (output valid, output cmd, output scan_byte, input ready);
   modport sink (input valid, input cmd, input scan_byte, output ready);
endinterface

// response channel: popped character, queue fill and modifier flags
interface sc2a_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [6:0] char_code;
   logic       push_dropped;
   logic [6:0] chars_waiting;
   logic       shift_held;
   logic       ctrl_held;
   logic       alt_held;
   logic       caps_on;

   modport source (output valid, output char_valid, output char_code,
                   output push_dropped, output chars_waiting, output shift_held,
                   output ctrl_held, output alt_held, output caps_on, input ready);
   modport sink (input valid, input char_valid, input char_code,
                 input push_dropped, input chars_waiting, input shift_held,
                 input ctrl_held, input alt_held, input caps_on, output ready);
endinterface

`default_nettype wire

### rtl/scancode_to_ascii_with_fifo.sv
// channel   dir  transfer when       payload
// req_ch    in   valid && ready      cmd, scan_byte
// rsp_ch    out  valid && ready      char_valid, char_code, push_dropped, chars_waiting, flags
//
// one request per cycle while req_ch.ready is high; its response is offered after the request transfer
// (translation, queue update and store read into a stage, then the output register)
// synchronous reset clears the pointers, fill count, modifier flags and the valid bits of both stages
// a stage and an output register part the channels: a request is taken while a
// response waits, and req_ch.ready drops only when both are full and rsp_ch stalls
`default_nettype none

module scancode_to_ascii_with_fifo #(
   parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEFAULT
) (
   input wire          clock,
   input wire          reset,
   sc2a_req_if.sink    req_ch,
   sc2a_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic                    accept;
   logic [6:0]              key;
   logic                    down;
   logic [6:0]              new_char;
   sc2a_pkg::fifo_ctrl_type fifo_ctrl;
   sc2a_pkg::fifo_stat_type fifo_stat;
   logic [CNT_W-1:0]        count_next;
   logic [6:0]              rd_data;
   logic                    char_valid;
   logic                    dropped;

   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;

   // stage after the queue update
   logic       s_valid_ff, s_valid_in;
   logic       s_char_valid_ff;
   logic       s_dropped_ff;
   logic [6:0] s_chars_ff;
   logic [3:0] s_flags_ff;

   // output register
   logic       o_valid_ff, o_valid_in;
   logic       o_char_valid_ff;
   logic [6:0] o_char_code_ff;
   logic       o_dropped_ff;
   logic [6:0] o_chars_ff;
   logic [3:0] o_flags_ff;

   logic move;

   assign move          = s_valid_ff && (!o_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s_valid_ff || move;
   assign accept        = req_ch.valid && req_ch.ready;
   assign key           = req_ch.scan_byte[6:0];
   assign down          = !req_ch.scan_byte[sc2a_pkg::RELEASE_BIT];

   // decode, modifier update and translation
   always_comb begin
      shift_in   = shift_ff;
      ctrl_in    = ctrl_ff;
      alt_in     = alt_ff;
      caps_in    = caps_ff;
      new_char   = sc2a_pkg::ASCII_NONE;
      fifo_ctrl  = '0;
      char_valid = 1'b0;
      dropped    = 1'b0;
      if (accept) begin
         unique case (req_ch.cmd)
            sc2a_pkg::CMD_SCAN: begin
               unique case (key)
                  sc2a_pkg::KEY_LSHIFT, sc2a_pkg::KEY_RSHIFT: shift_in = down;
                  sc2a_pkg::KEY_CTRL: ctrl_in = down;
                  sc2a_pkg::KEY_ALT: alt_in = down;
                  sc2a_pkg::KEY_CAPS: begin
                     if (down) begin
                        caps_in = !caps_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               if (down) begin
                  priority if (key == sc2a_pkg::KEY_ENTER) begin
                     new_char = sc2a_pkg::ASCII_NEWLINE;
                  end else if (key == sc2a_pkg::KEY_BACKSPACE) begin
                     new_char = sc2a_pkg::ASCII_BACKSPACE;
                  end else if (key == sc2a_pkg::KEY_TAB) begin
                     new_char = sc2a_pkg::ASCII_TAB;
                  end else begin
                     new_char = sc2a_pkg::key_to_char(shift_in ^ caps_in, key);
                  end
               end
               // drop the character when the queue is full
               if (new_char != sc2a_pkg::ASCII_NONE) begin
                  if (fifo_stat.full) begin
                     dropped = 1'b1;
                  end else begin
                     fifo_ctrl.push = 1'b1;
                  end
               end
            end
            sc2a_pkg::CMD_POP: begin
               if (!fifo_stat.empty) begin
                  fifo_ctrl.pop = 1'b1;
                  char_valid    = 1'b1;
               end
            end
            sc2a_pkg::CMD_FLUSH: fifo_ctrl.flush = 1'b1;
            default: begin
            end
         endcase
      end
   end

   sc2a_char_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fifo_ctrl),
      .push_char  (new_char),
      .stat       (fifo_stat),
      .count_next (count_next),
      .rd_data    (rd_data)
   );

   // modifier flags
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         caps_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         caps_ff  <= caps_in;
      end
   end

   // stage and output valid bits
   always_comb begin
      s_valid_in = s_valid_ff;
      if (accept) begin
         s_valid_in = 1'b1;
      end else if (move) begin
         s_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (move) begin
         o_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // stage payload, the character itself arrives from the store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s_char_valid_ff <= char_valid;
         s_dropped_ff    <= dropped;
         s_chars_ff      <= 7'(count_next);
         s_flags_ff      <= {shift_in, ctrl_in, alt_in, caps_in};
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (move) begin
         o_char_valid_ff <= s_char_valid_ff;
         o_char_code_ff  <= s_char_valid_ff ? rd_data : sc2a_pkg::ASCII_NONE;
         o_dropped_ff    <= s_dropped_ff;
         o_chars_ff      <= s_chars_ff;
         o_flags_ff      <= s_flags_ff;
      end
   end

   assign rsp_ch.valid         = o_valid_ff;
   assign rsp_ch.char_valid    = o_char_valid_ff;
   assign rsp_ch.char_code     = o_char_code_ff;
   assign rsp_ch.push_dropped  = o_dropped_ff;
   assign rsp_ch.chars_waiting = o_chars_ff;
   assign rsp_ch.shift_held    = o_flags_ff[3];
   assign rsp_ch.ctrl_held     = o_flags_ff[2];
   assign rsp_ch.alt_held      = o_flags_ff[1];
   assign rsp_ch.caps_on       = o_flags_ff[0];

endmodule

`default_nettype wire

### rtl/sc2a_char_fifo.sv
`default_nettype none

module sc2a_char_fifo #(
   parameter int DEPTH = sc2a_pkg::FIFO_DEPTH_DEFAULT,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire sc2a_pkg::fifo_ctrl_type ctrl,
   input  wire  [6:0]                  push_char,
   output sc2a_pkg::fifo_stat_type     stat,
   output logic [CNT_W-1:0]            count_next,
   output logic [6:0]                  rd_data
);

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [6:0]       mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [6:0]       rd_data_ff;

   // status from the current fill
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

   // pointer and fill update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      priority if (ctrl.flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end else if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // character store write
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= push_char;
      end
   end

   // registered read, held until the next pop
   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign count_next = count_in;
   assign rd_data    = rd_data_ff;

endmodule

`default_nettype wire

### rtl/sc2a_checker.sv
`default_nettype none
`include "scancode_to_ascii_with_fifo_defines.svh"

module sc2a_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_char_valid,
   input wire [6:0] rsp_char_code,
   input wire       rsp_push_dropped
);

   logic req_fire;
   logic code_nonzero;

   assign req_fire     = req_valid && req_ready;
   assign code_nonzero = (rsp_char_code != 7'd0);

   // a stalled response stays offered
   `SC2A_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // only nonzero characters enter the queue, so a pop shows one exactly when valid
   `SC2A_ASSERT(a_code_matches_valid, clock, reset, rsp_valid |-> (rsp_char_valid == code_nonzero))

   // a pop never reports a dropped push
   `SC2A_ASSERT(a_pop_no_drop, clock, reset, rsp_valid && rsp_char_valid |-> !rsp_push_dropped)

   // both stages are empty right after reset, so requests are taken
   `SC2A_ASSERT_ALWAYS(a_ready_after_reset, clock, !reset && $past(reset) |-> req_ready && !rsp_valid)

   // a response never appears without an earlier request transfer
   `SC2A_ASSERT(a_no_early_rsp, clock, reset, !rsp_valid && !$past(req_fire) |=> !rsp_valid)

endmodule

bind scancode_to_ascii_with_fifo sc2a_checker u_sc2a_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_char_valid   (rsp_ch.char_valid),
   .rsp_char_code    (rsp_ch.char_code),
   .rsp_push_dropped (rsp_ch.push_dropped)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int QUEUE_DEPTH = sc2a_pkg::FIFO_DEPTH_DEFAULT;
   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_LIMIT = 500;
   localparam int DRAIN_CYCLES = 10;

   // the one command code the block does not decode
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_ANY, IDLE_SOME} idle_mode_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
      logic       push_dropped;
      logic [6:0] chars_waiting;
      logic       shift_held;
      logic       ctrl_held;
      logic       alt_held;
      logic       caps_on;
   } kbd_rsp_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  scan;
      logic        typed;
      kbd_rsp_type want;
   } stim_row_type;

   localparam kbd_rsp_type RSP_QUIET = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sc2a_req_if req_ch ();
   sc2a_rsp_if rsp_ch ();

   scancode_to_ascii_with_fifo u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   // set-1 key layouts, keys 0x00 to 0x3f; higher keys give no character
   logic [7:0] lower_keys [0:63] = '{
      8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h00, 8'h00,
      "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h00, 8'h00, "a", "s",
      "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60, 8'h00, "\\", "z", "x", "c", "v",
      "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " ", 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00
   };
   logic [7:0] upper_keys [0:63] = '{
      8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h00, 8'h00,
      "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h00, 8'h00, "A", "S",
      "D", "F", "G", "H", "J", "K", "L", ":", "\"", "~", 8'h00, "|", "Z", "X", "C", "V",
      "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " ", 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00
   };

   // directed rows: reset-state rows carry a typed response, the rest use the predictor
   stim_row_type directed_rows [0:25] = '{
      {sc2a_pkg::CMD_POP, 8'h00, 1'b1, RSP_QUIET},
      {CMD_UNUSED, 8'hFF, 1'b1, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h00, 1'b1, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'hFF, 1'b1, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h1E, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_ENTER, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_BACKSPACE, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_TAB, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_LSHIFT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h1E, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h39, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h37, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b1, sc2a_pkg::KEY_LSHIFT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_RSHIFT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b1, sc2a_pkg::KEY_RSHIFT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_CAPS, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b1, sc2a_pkg::KEY_CAPS, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 8'h10, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_CTRL, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_ALT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b1, sc2a_pkg::KEY_CTRL, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b1, sc2a_pkg::KEY_ALT, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_POP, 8'h00, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_FLUSH, 8'h00, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_SCAN, 1'b0, sc2a_pkg::KEY_CAPS, 1'b0, RSP_QUIET},
      {sc2a_pkg::CMD_POP, 8'hFF, 1'b0, RSP_QUIET}
   };

   // predictor state
   logic [6:0] char_mem [0:QUEUE_DEPTH-1];
   int         rd_idx = 0;
   int         wr_idx = 0;
   int         fill_level = 0;
   logic       shift_q = 1'b0;
   logic       ctrl_q = 1'b0;
   logic       alt_q = 1'b0;
   logic       caps_q = 1'b0;

   kbd_rsp_type   kbd_replies [$];
   int            mismatches = 0;
   int            idle_cycles = 0;
   int            random_sent = 0;
   idle_mode_type req_idle = IDLE_NONE;
   idle_mode_type rsp_idle = IDLE_NONE;

   // keyboard translation and character queue, one request at a time
   function automatic kbd_rsp_type translate_request(input logic [1:0] cmd,
                                                     input logic [7:0] scan);
      kbd_rsp_type r;
      logic        pressed;
      logic [6:0]  key;
      logic [7:0]  ascii;
      r = '0;
      pressed = ~scan[sc2a_pkg::RELEASE_BIT];
      key = scan[6:0];
      ascii = 8'h00;
      case (cmd)
         sc2a_pkg::CMD_SCAN: begin
            if (key == sc2a_pkg::KEY_LSHIFT || key == sc2a_pkg::KEY_RSHIFT) begin
               shift_q = pressed;
            end else if (key == sc2a_pkg::KEY_CTRL) begin
               ctrl_q = pressed;
            end else if (key == sc2a_pkg::KEY_ALT) begin
               alt_q = pressed;
            end else if (key == sc2a_pkg::KEY_CAPS && pressed) begin
               caps_q = ~caps_q;
            end
            if (pressed) begin
               if (key == sc2a_pkg::KEY_ENTER) begin
                  ascii = {1'b0, sc2a_pkg::ASCII_NEWLINE};
               end else if (key == sc2a_pkg::KEY_BACKSPACE) begin
                  ascii = {1'b0, sc2a_pkg::ASCII_BACKSPACE};
               end else if (key == sc2a_pkg::KEY_TAB) begin
                  ascii = {1'b0, sc2a_pkg::ASCII_TAB};
               end else if (key < 7'd64) begin
                  ascii = (shift_q ^ caps_q) ? upper_keys[key[5:0]] : lower_keys[key[5:0]];
               end
               if (ascii != 8'h00) begin
                  if (fill_level == QUEUE_DEPTH) begin
                     r.push_dropped = 1'b1;
                  end else begin
                     char_mem[wr_idx] = ascii[6:0];
                     wr_idx = (wr_idx + 1) % QUEUE_DEPTH;
                     fill_level++;
                  end
               end
            end
         end
         sc2a_pkg::CMD_POP: begin
            if (fill_level != 0) begin
               r.char_valid = 1'b1;
               r.char_code = char_mem[rd_idx];
               rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
               fill_level--;
            end
         end
         sc2a_pkg::CMD_FLUSH: begin
            rd_idx = 0;
            wr_idx = 0;
            fill_level = 0;
         end
         default: begin
         end
      endcase
      r.chars_waiting = fill_level[6:0];
      r.shift_held = shift_q;
      r.ctrl_held = ctrl_q;
      r.alt_held = alt_q;
      r.caps_on = caps_q;
      return r;
   endfunction

   function automatic int draw_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_ANY: return $urandom_range(0, 14);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      endcase
   endfunction

   function automatic int field_diff(input string field, input logic [6:0] want,
                                     input logic [6:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // one request transfer, then log what the block should answer
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] scan,
                               input logic typed, input kbd_rsp_type want);
      int          gap;
      kbd_rsp_type predicted;
      gap = draw_idle(req_idle);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.scan_byte <= scan;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = translate_request(cmd, scan);
      kbd_replies.push_back(typed ? want : predicted);
   endtask

   task automatic issue(input logic [1:0] cmd, input logic [7:0] scan);
      send_request(cmd, scan, 1'b0, RSP_QUIET);
      random_sent++;
   endtask

   // typing burst; pop rate per thousand sets whether the queue fills or drains
   task automatic run_phase(input int len, input int pop_pm);
      int         r;
      int         pick;
      logic [6:0] key;
      for (int i = 0; i < len && random_sent < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 999);
         pick = $urandom_range(0, 255);
         if (r < pop_pm) begin
            issue(sc2a_pkg::CMD_POP, pick[7:0]);
         end else if (r < pop_pm + 4) begin
            issue(sc2a_pkg::CMD_FLUSH, pick[7:0]);
         end else if (r < pop_pm + 12) begin
            issue(CMD_UNUSED, pick[7:0]);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  // key press, often followed by its release
                  r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 58);
                  key = r[6:0];
                  issue(sc2a_pkg::CMD_SCAN, {1'b0, key});
                  if (pick[0]) begin
                     issue(sc2a_pkg::CMD_SCAN, {1'b1, key});
                  end
               end
               6: issue(sc2a_pkg::CMD_SCAN,
                        {pick[0], pick[1] ? sc2a_pkg::KEY_LSHIFT : sc2a_pkg::KEY_RSHIFT});
               7: issue(sc2a_pkg::CMD_SCAN,
                        {pick[0], pick[1] ? sc2a_pkg::KEY_CTRL : sc2a_pkg::KEY_ALT});
               8: issue(sc2a_pkg::CMD_SCAN, {pick[0], sc2a_pkg::KEY_CAPS});
               default: issue(sc2a_pkg::CMD_SCAN, pick[7:0]);
            endcase
         end
      end
   endtask

   // stimulus: reset, directed rows, random phases, then drain
   initial begin
      int phase_kind;
      int phase_no;
      req_ch.valid = 1'b0;
      req_ch.cmd = sc2a_pkg::CMD_SCAN;
      req_ch.scan_byte = 8'h00;
      phase_no = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].scan,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      while (random_sent < RANDOM_ITEMS) begin
         req_idle = idle_mode_type'($urandom_range(0, 2));
         phase_kind = (phase_no == 0) ? 0 : $urandom_range(0, 2);
         case (phase_kind)
            0: run_phase($urandom_range(150, 300), 0);
            1: run_phase($urandom_range(60, 200), 350);
            default: run_phase($urandom_range(40, 120), 750);
         endcase
         phase_no++;
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (kbd_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // response side: random stalls, each transfer checked against the oldest prediction
   initial begin
      int          stall;
      kbd_rsp_type got;
      kbd_rsp_type want;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_idle(rsp_idle);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = {rsp_ch.char_valid, rsp_ch.char_code, rsp_ch.push_dropped,
                rsp_ch.chars_waiting, rsp_ch.shift_held, rsp_ch.ctrl_held,
                rsp_ch.alt_held, rsp_ch.caps_on};
         if (kbd_replies.size() == 0) begin
            $error("response transfer with nothing outstanding");
            mismatches++;
         end else begin
            want = kbd_replies.pop_front();
            mismatches += field_diff("char_valid", 7'(want.char_valid), 7'(got.char_valid));
            mismatches += field_diff("char_code", want.char_code, got.char_code);
            mismatches += field_diff("push_dropped", 7'(want.push_dropped),
                                     7'(got.push_dropped));
            mismatches += field_diff("chars_waiting", want.chars_waiting, got.chars_waiting);
            mismatches += field_diff("shift_held", 7'(want.shift_held), 7'(got.shift_held));
            mismatches += field_diff("ctrl_held", 7'(want.ctrl_held), 7'(got.ctrl_held));
            mismatches += field_diff("alt_held", 7'(want.alt_held), 7'(got.alt_held));
            mismatches += field_diff("caps_on", 7'(want.caps_on), 7'(got.caps_on));
         end
         if ($urandom_range(0, 59) == 0) begin
            rsp_idle = idle_mode_type'($urandom_range(0, 2));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### scancode_to_ascii_with_fifo.f
+incdir+rtl
rtl/sc2a_pkg.sv
rtl/sc2a_if.sv
rtl/sc2a_char_fifo.sv
rtl/scancode_to_ascii_with_fifo.sv
rtl/sc2a_checker.sv
verif/tb.sv
